// File: hdl/fwrl_pkg.sv
// Package for the fixed-window three-class rate limiter.
// Request and result payload types, configuration register indexes and widths.
// No dependencies.
package fwrl_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOTAL_LIMIT     = 8'd0,
    CFG_TRADING_LIMIT   = 8'd1,
    CFG_HEARTBEAT_LIMIT = 8'd2,
    CFG_WINDOW_LENGTH   = 8'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_SEND  = 1'b0,
    KIND_CLEAR = 1'b1
  } req_kind_e;

  localparam logic [CountW-1:0] LimitReset  = 32'd1;
  localparam logic [CountW-1:0] WindowReset = 32'd1000;

  typedef struct packed {
    logic             kind;
    logic [TimeW-1:0] now_time;
    logic             count_total;
    logic             count_trading;
    logic             count_heartbeat;
  } fwrl_req_t;

  typedef struct packed {
    logic              allowed;
    logic              total_violation;
    logic              trading_violation;
    logic              heartbeat_violation;
    logic [TimeW-1:0]  retry_after;
    logic [CountW-1:0] total_count;
    logic [CountW-1:0] trading_count;
    logic [CountW-1:0] heartbeat_count;
  } fwrl_rsp_t;

  // A limit or length written as zero behaves as one.
  function automatic logic [CountW-1:0] at_least_one(input logic [CountW-1:0] v);
    at_least_one = (v == '0) ? {{(CountW-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

// File: hdl/fixed_window_three_class_rate_limiter_unit.sv
// Fixed-window three-class rate limiter, top level.
// Input request register, combinational decision logic, result register.
// Depends on fwrl_pkg.

// Takes one request per clock cycle unless a send request is held by a full result
// register. A send request's result passes from the input register to the result register;
// a clear request gives none.
// The window and counter update is combinational compare and increment logic feeding
// back into the state registers, which sets the one-per-cycle rate. The result register
// decouples the two sides: the input register can take a request while a result waits.
// Configuration writes are always accepted and take effect on the next cycle.
module fixed_window_three_class_rate_limiter_unit
  import fwrl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fwrl_req_t           in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fwrl_rsp_t           out_rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [CountW-1:0] tot_lim_q, trd_lim_q, hb_lim_q, win_len_q;

  logic              req_valid_q;
  fwrl_req_t         req_q;
  logic              out_valid_q;
  fwrl_rsp_t         out_q;

  logic [TimeW-1:0]  win_start_q, win_start_d;
  logic [CountW-1:0] tot_q, trd_q, hb_q;
  logic [CountW-1:0] tot_d, trd_d, hb_d;

  logic              advance;
  logic              is_clear;
  logic [TimeW-1:0]  now_m;
  logic [TimeW-1:0]  elapsed;
  logic              expired, restart;
  logic [CountW-1:0] tot_b, trd_b, hb_b;
  logic              viol_tot, viol_trd, viol_hb, allow;
  fwrl_rsp_t         rsp_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_lim_q <= LimitReset;
      trd_lim_q <= LimitReset;
      hb_lim_q  <= LimitReset;
      win_len_q <= WindowReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TOTAL_LIMIT:     tot_lim_q <= at_least_one(cfg_data_i);
        CFG_TRADING_LIMIT:   trd_lim_q <= at_least_one(cfg_data_i);
        CFG_HEARTBEAT_LIMIT: hb_lim_q  <= at_least_one(cfg_data_i);
        CFG_WINDOW_LENGTH:   win_len_q <= at_least_one(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Handshake: a clear request needs no room in the result register.
  assign is_clear   = (req_q.kind == KIND_CLEAR);
  assign advance    = req_valid_q && (is_clear || !out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
  end

  // Window logic
  assign now_m   = req_q.now_time;
  assign elapsed = now_m - win_start_q;
  assign expired = (now_m >= win_start_q) && (elapsed >= TimeW'(win_len_q));
  assign restart = (tot_q == '0) || expired;

  assign win_start_d = restart ? now_m : win_start_q;
  assign tot_b       = restart ? '0 : tot_q;
  assign trd_b       = restart ? '0 : trd_q;
  assign hb_b        = restart ? '0 : hb_q;

  // Priority: total, trading, heartbeat
  assign viol_tot = req_q.count_total && (tot_b >= tot_lim_q);
  assign viol_trd = !viol_tot && req_q.count_trading && (trd_b >= trd_lim_q);
  assign viol_hb  = !viol_tot && !viol_trd && req_q.count_heartbeat && (hb_b >= hb_lim_q);
  assign allow    = !(viol_tot || viol_trd || viol_hb);

  assign tot_d = (allow && req_q.count_total && (tot_b != '1)) ? tot_b + 1'b1 : tot_b;
  assign trd_d = (allow && req_q.count_trading && (trd_b != '1)) ? trd_b + 1'b1 : trd_b;
  assign hb_d  = (allow && req_q.count_heartbeat && (hb_b != '1)) ? hb_b + 1'b1 : hb_b;

  always_comb begin
    rsp_d                     = '0;
    rsp_d.allowed             = allow;
    rsp_d.total_violation     = viol_tot;
    rsp_d.trading_violation   = viol_trd;
    rsp_d.heartbeat_violation = viol_hb;
    rsp_d.retry_after         = allow ? '0 :
                                win_start_d + TimeW'(win_len_q) - now_m;
    rsp_d.total_count         = tot_d;
    rsp_d.trading_count       = trd_d;
    rsp_d.heartbeat_count     = hb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      tot_q       <= '0;
      trd_q       <= '0;
      hb_q        <= '0;
    end else if (advance) begin
      if (is_clear) begin
        win_start_q <= '0;
        tot_q       <= '0;
        trd_q       <= '0;
        hb_q        <= '0;
      end else begin
        win_start_q <= win_start_d;
        tot_q       <= tot_d;
        trd_q       <= trd_d;
        hb_q        <= hb_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && !is_clear) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && !is_clear) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef NO_ASSERTIONS
  a_one_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($onehot0({out_rsp_o.total_violation, out_rsp_o.trading_violation,
                               out_rsp_o.heartbeat_violation}) &&
                     (out_rsp_o.allowed == !(out_rsp_o.total_violation ||
                                             out_rsp_o.trading_violation ||
                                             out_rsp_o.heartbeat_violation))))
    else $error("result violation flags inconsistent");

  a_allow_no_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.allowed) |-> (out_rsp_o.retry_after == '0))
    else $error("allowed result carries a retry time");

  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_clear) |=> (tot_q == '0 && trd_q == '0 && hb_q == '0 &&
                              win_start_q == '0))
    else $error("clear request left window state");

  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_clear && !out_valid_q) |=> !out_valid_q)
    else $error("clear request produced a result");
`endif

endmodule

// File: tb/sv/fixed_window_three_class_rate_limiter_unit_tb.sv
// Testbench for the fixed-window three-class rate limiter unit.
// A scoreboard class predicts each send decision; plain tasks drive requests and registers.
// Depends on fwrl_pkg and fixed_window_three_class_rate_limiter_unit.
module fixed_window_three_class_rate_limiter_unit_tb;
  import fwrl_pkg::*;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum int {
    VIOL_NONE,
    VIOL_TOTAL,
    VIOL_TRADING,
    VIOL_HEARTBEAT
  } viol_e;

  class window_scoreboard;
    logic [CountW-1:0] total_lim, trading_lim, hb_lim, win_len;
    logic [TimeW-1:0]  win_start;
    logic [CountW-1:0] total_used, trading_used, hb_used;
    fwrl_rsp_t         decisions_due[$];
    int unsigned       mismatches;

    function new();
      total_lim    = LimitReset;
      trading_lim  = LimitReset;
      hb_lim       = LimitReset;
      win_len      = WindowReset;
      win_start    = '0;
      total_used   = '0;
      trading_used = '0;
      hb_used      = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      logic [CountW-1:0] v;
      v = (d == '0) ? 32'd1 : d;
      case (idx)
        CFG_TOTAL_LIMIT:     total_lim = v;
        CFG_TRADING_LIMIT:   trading_lim = v;
        CFG_HEARTBEAT_LIMIT: hb_lim = v;
        CFG_WINDOW_LENGTH:   win_len = v;
        default: ;
      endcase
    endfunction

    function void note_request(fwrl_req_t r);
      fwrl_rsp_t d;
      logic      expired;
      viol_e     verdict;
      if (r.kind == KIND_CLEAR) begin
        win_start    = '0;
        total_used   = '0;
        trading_used = '0;
        hb_used      = '0;
        return;
      end
      expired = (r.now_time >= win_start) &&
                ((r.now_time - win_start) >= {{(TimeW-CountW){1'b0}}, win_len});
      if (total_used == '0 || expired) begin
        win_start    = r.now_time;
        total_used   = '0;
        trading_used = '0;
        hb_used      = '0;
      end
      verdict = VIOL_NONE;
      if (r.count_total && total_used >= total_lim) verdict = VIOL_TOTAL;
      else if (r.count_trading && trading_used >= trading_lim) verdict = VIOL_TRADING;
      else if (r.count_heartbeat && hb_used >= hb_lim) verdict = VIOL_HEARTBEAT;
      d = '0;
      if (verdict == VIOL_NONE) begin
        if (r.count_total && total_used != '1) total_used++;
        if (r.count_trading && trading_used != '1) trading_used++;
        if (r.count_heartbeat && hb_used != '1) hb_used++;
        d.allowed = 1'b1;
      end else begin
        d.retry_after = win_start + {{(TimeW-CountW){1'b0}}, win_len} - r.now_time;
      end
      d.total_violation     = (verdict == VIOL_TOTAL);
      d.trading_violation   = (verdict == VIOL_TRADING);
      d.heartbeat_violation = (verdict == VIOL_HEARTBEAT);
      d.total_count         = total_used;
      d.trading_count       = trading_used;
      d.heartbeat_count     = hb_used;
      decisions_due.push_back(d);
    endfunction

    function void compare_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: expected %0h, got %0h", name, e, a);
      end
    endfunction

    function void check_result(fwrl_rsp_t a);
      fwrl_rsp_t e;
      if (decisions_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request outstanding: %0h", a);
        return;
      end
      e = decisions_due.pop_front();
      compare_field("allowed", 64'(e.allowed), 64'(a.allowed));
      compare_field("total_violation", 64'(e.total_violation), 64'(a.total_violation));
      compare_field("trading_violation", 64'(e.trading_violation),
                    64'(a.trading_violation));
      compare_field("heartbeat_violation", 64'(e.heartbeat_violation),
                    64'(a.heartbeat_violation));
      compare_field("retry_after", 64'(e.retry_after), 64'(a.retry_after));
      compare_field("total_count", 64'(e.total_count), 64'(a.total_count));
      compare_field("trading_count", 64'(e.trading_count), 64'(a.trading_count));
      compare_field("heartbeat_count", 64'(e.heartbeat_count), 64'(a.heartbeat_count));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  fwrl_req_t           in_req_i;
  logic                out_valid_o;
  logic                out_ready_i;
  fwrl_rsp_t           out_rsp_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  window_scoreboard sb;
  int               sender_pct;
  int               receiver_pct;
  logic             hold_toggle;
  logic [TimeW-1:0] span;

  fixed_window_three_class_rate_limiter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic fwrl_req_t mk(logic kind, logic [TimeW-1:0] t,
                                   logic ct, logic ctr, logic ch);
    fwrl_req_t r;
    r.kind            = kind;
    r.now_time        = t;
    r.count_total     = ct;
    r.count_trading   = ctr;
    r.count_heartbeat = ch;
    return r;
  endfunction

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    int   hold_left;
    logic hold_seen;
    hold_left   = 0;
    hold_seen   = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_rsp_o);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !roll(receiver_pct);
      end
    end
  end

  task automatic send_req(input fwrl_req_t r);
    while (roll(sender_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] tl, trl, hl, wl);
    cfg_write(CFG_TOTAL_LIMIT, tl);
    cfg_write(CFG_TRADING_LIMIT, trl);
    cfg_write(CFG_HEARTBEAT_LIMIT, hl);
    cfg_write(CFG_WINDOW_LENGTH, wl);
    // unknown index must be ignored
    cfg_write(CfgIdxW'($urandom_range(4, 255)), $urandom());
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    span = (wl == '0) ? 48'd1 : ((wl > 32'd1000) ? 48'd1000 : TimeW'(wl));
  endtask

  // Lets every outstanding request finish, clears included
  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.decisions_due.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    fwrl_req_t        directed_q[$];
    fwrl_req_t        item;
    logic [TimeW-1:0] cur_time;
    logic [63:0]      wide;
    int               sel;

    sb           = new();
    sender_pct   = 0;
    receiver_pct <= 0;
    hold_toggle  <= 1'b0;
    span         = 48'd1000;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_req_i     <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests on reset settings: limits one, window 1000
    directed_q.push_back(mk(KIND_SEND, 48'd0, 1'b0, 1'b0, 1'b0));
    directed_q.push_back(mk(KIND_SEND, 48'd10, 1'b1, 1'b0, 1'b0));
    directed_q.push_back(mk(KIND_SEND, 48'd20, 1'b1, 1'b0, 1'b0));
    directed_q.push_back(mk(KIND_SEND, 48'd30, 1'b0, 1'b1, 1'b0));
    directed_q.push_back(mk(KIND_SEND, 48'd40, 1'b0, 1'b1, 1'b0));
    directed_q.push_back(mk(KIND_SEND, 48'd50, 1'b0, 1'b0, 1'b1));
    directed_q.push_back(mk(KIND_SEND, 48'd60, 1'b0, 1'b0, 1'b1));
    directed_q.push_back(mk(KIND_SEND, 48'd70, 1'b1, 1'b1, 1'b1));
    directed_q.push_back(mk(KIND_SEND, 48'd80, 1'b0, 1'b1, 1'b1));
    directed_q.push_back(mk(KIND_SEND, 48'd5, 1'b1, 1'b0, 1'b0));
    directed_q.push_back(mk(KIND_SEND, 48'd1010, 1'b1, 1'b0, 1'b0));
    directed_q.push_back(mk(KIND_SEND, TimeMax - 48'd99, 1'b1, 1'b0, 1'b0));
    directed_q.push_back(mk(KIND_SEND, TimeMax, 1'b1, 1'b0, 1'b0));
    directed_q.push_back(mk(KIND_SEND, 48'd0, 1'b1, 1'b0, 1'b0));
    directed_q.push_back(mk(KIND_CLEAR, TimeMax, 1'b1, 1'b1, 1'b1));
    directed_q.push_back(mk(KIND_SEND, 48'd0, 1'b1, 1'b0, 1'b0));
    directed_q.push_back(mk(KIND_CLEAR, 48'd0, 1'b0, 1'b0, 1'b0));
    directed_q.push_back(mk(KIND_SEND, 48'd100, 1'b0, 1'b1, 1'b0));
    directed_q.push_back(mk(KIND_SEND, 48'd200, 1'b0, 1'b0, 1'b0));
    directed_q.push_back(mk(KIND_SEND, 48'd210, 1'b0, 1'b1, 1'b0));
    directed_q.push_back(mk(KIND_SEND, TimeMax, 1'b1, 1'b1, 1'b1));
    foreach (directed_q[i]) send_req(directed_q[i]);
    drain();

    cur_time = '0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: program_regs(32'd4, 32'd2, 32'd3, 32'd50);
        1: program_regs(32'd0, 32'd0, 32'd0, 32'd0);
        2: program_regs('1, '1, '1, '1);
        3: program_regs(32'd1, 32'd1, 32'd1, 32'd1);
        4: program_regs($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                        $urandom_range(1, 300));
        5: program_regs($urandom(), $urandom(), $urandom(), $urandom());
        6: program_regs($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5),
                        $urandom_range(0, 80));
        default: program_regs(32'd3, '1, 32'd2, 32'd20);
      endcase
      sender_pct   = ((phase % 4) == 1) ? 83 : (((phase % 4) == 3) ? 28 : 0);
      receiver_pct <= ((phase % 4) == 2) ? 83 : (((phase % 4) == 3) ? 28 : 0);
      if (phase == 4) hold_toggle <= ~hold_toggle;

      for (int n = 0; n < 215; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) cur_time = cur_time + $urandom_range(0, int'(span) / 4 + 1);
        else if (sel < 80) cur_time = cur_time + $urandom_range(0, 2 * int'(span));
        else if (sel < 88) cur_time = cur_time - $urandom_range(0, int'(span));
        else if (sel < 94) begin
          wide     = {$urandom(), $urandom()};
          cur_time = wide[TimeW-1:0];
        end else cur_time = TimeMax - $urandom_range(0, 2 * int'(span));
        item.kind     = ($urandom_range(0, 99) < 4) ? KIND_CLEAR : KIND_SEND;
        item.now_time = cur_time;
        {item.count_total, item.count_trading, item.count_heartbeat} = 3'($urandom_range(0, 7));
        send_req(item);
      end
      drain();
    end

    if (sb.decisions_due.size() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: fixed_window_three_class_rate_limiter_unit.f
hdl/fwrl_pkg.sv
hdl/fixed_window_three_class_rate_limiter_unit.sv
tb/sv/fixed_window_three_class_rate_limiter_unit_tb.sv
